[rtl/rbsi_pkg.sv]
`default_nettype none

package rbsi_pkg;

    localparam int CB      = 32;
    localparam int FB      = 16;
    localparam int HB      = CB - 1;
    localparam int NW      = CB + 2 + FB;
    localparam int NMW     = CB + 1 + FB;
    localparam int DIV_LAT = CB + 3;

    typedef logic signed [CB-1:0] coord_t;

    localparam coord_t VMAX = {1'b0, {(CB-1){1'b1}}};
    localparam coord_t VMIN = {1'b1, {(CB-1){1'b0}}};

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_HALF_X   = 3'd3,
        REG_HALF_Y   = 3'd4,
        REG_HALF_Z   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        coord_t origin_x;
        coord_t origin_y;
        coord_t origin_z;
        coord_t dir_x;
        coord_t dir_y;
        coord_t dir_z;
    } in_word_t;

    typedef struct packed {
        logic       hit;
        coord_t     hit_x;
        coord_t     hit_y;
        coord_t     hit_z;
        logic [1:0] normal_axis;
        logic       normal_negative;
        logic       saturated;
    } out_word_t;

    // ray data that rides alongside the dividers, index 0 is x
    typedef struct packed {
        logic                valid;
        logic [2:0][CB-1:0] o;
        logic [2:0][CB-1:0] d;
        logic [2:0]          dz;
        logic [2:0]          slab_out;
    } ray_side_t;

    typedef struct packed {
        ray_side_t  side;
        coord_t     tmin;
        coord_t     tmax;
        logic [1:0] axis;
        logic       miss;
        logic       sat;
    } fold_t;

endpackage

`default_nettype wire

[rtl/ray_box_slab_intersect.sv]
// Ray against axis-aligned box, slab test in signed Q16.16. Takes one ray per
// clock unless stalled and returns one result word per ray, in order, through
// an input register, a numerator stage, the six slab dividers (35 stages each,
// including one per quotient bit), a swap stage, one fold stage per axis, a
// multiply stage and the output register. The whole pipeline holds while a
// finished word waits on out_stall. The user must write box registers through
// cfg_wr/cfg_addr/cfg_data only with no ray in flight; the block never checks.
`default_nettype none

module ray_box_slab_intersect
    import rbsi_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_wr,
    input  wire logic [2:0] cfg_addr,
    input  wire logic [CB-1:0] cfg_data,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_word_t  in_word,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_word_t      out_word
);

    logic [2:0][CB-1:0]    center_reg;
    logic [2:0][HB-1:0]    half_reg;

    logic                  en;
    logic                  p0_valid_reg;
    in_word_t              p0_word_reg;

    logic signed [NW-1:0]  num_hi_reg [3];
    logic signed [NW-1:0]  num_lo_reg [3];
    logic signed [NW-1:0]  num_hi_next [3];
    logic signed [NW-1:0]  num_lo_next [3];
    ray_side_t             p1_side_reg;
    ray_side_t             p1_side_next;

    ray_side_t             side_reg [0:DIV_LAT-1];

    logic [2:0][CB-1:0]    t1;
    logic [2:0][CB-1:0]    t2;
    logic [2:0]            s1;
    logic [2:0]            s2;
    fold_t                 fold_res;

    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                center_reg[i] <= '0;
                half_reg[i]   <= HB'(1) << FB;
            end
        end
        else if (cfg_wr)
        begin
            case (cfg_addr)
                REG_CENTER_X: center_reg[0] <= cfg_data;
                REG_CENTER_Y: center_reg[1] <= cfg_data;
                REG_CENTER_Z: center_reg[2] <= cfg_data;
                REG_HALF_X:   half_reg[0]   <= cfg_data[HB-1:0];
                REG_HALF_Y:   half_reg[1]   <= cfg_data[HB-1:0];
                REG_HALF_Z:   half_reg[2]   <= cfg_data[HB-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        logic [2:0][CB-1:0]  o;
        logic [2:0][CB-1:0]  d;
        logic signed [CB:0]   e;
        logic signed [CB:0]   hx;
        logic signed [CB+1:0] sp;
        logic signed [CB+1:0] sm;
        o = {p0_word_reg.origin_z, p0_word_reg.origin_y, p0_word_reg.origin_x};
        d = {p0_word_reg.dir_z, p0_word_reg.dir_y, p0_word_reg.dir_x};
        p1_side_next       = '0;
        p1_side_next.valid = p0_valid_reg;
        p1_side_next.o     = o;
        p1_side_next.d     = d;
        for (int i = 0; i < 3; i++)
        begin
            e  = $signed({center_reg[i][CB-1], center_reg[i]}) - $signed({o[i][CB-1], o[i]});
            hx = $signed({2'b00, half_reg[i]});
            sp = $signed({e[CB], e}) + $signed({3'b000, half_reg[i]});
            sm = $signed({e[CB], e}) - $signed({3'b000, half_reg[i]});
            num_hi_next[i] = {sp, {FB{1'b0}}};
            num_lo_next[i] = {sm, {FB{1'b0}}};
            p1_side_next.dz[i]       = d[i] == '0;
            // origin outside this slab when the ray runs parallel to it
            p1_side_next.slab_out[i] = (e > hx) || (e < -hx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg <= 1'b0;
            p1_side_reg  <= '0;
            for (int k = 0; k < DIV_LAT; k++)
                side_reg[k] <= '0;
        end
        else if (en)
        begin
            p0_valid_reg <= in_valid;
            p1_side_reg  <= p1_side_next;
            side_reg[0]  <= p1_side_reg;
            for (int k = 1; k < DIV_LAT; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_word_reg <= in_word;
            for (int i = 0; i < 3; i++)
            begin
                num_hi_reg[i] <= num_hi_next[i];
                num_lo_reg[i] <= num_lo_next[i];
            end
        end
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_axis
        rbsi_div u_div_hi (
            .clk (clk),
            .en  (en),
            .num (num_hi_reg[g]),
            .den (coord_t'(p1_side_reg.d[g])),
            .quo (t1[g]),
            .sat (s1[g])
        );

        rbsi_div u_div_lo (
            .clk (clk),
            .en  (en),
            .num (num_lo_reg[g]),
            .den (coord_t'(p1_side_reg.d[g])),
            .quo (t2[g]),
            .sat (s2[g])
        );
    end

    rbsi_fold u_fold (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .t1       (t1),
        .t2       (t2),
        .tsat     (s1 | s2),
        .side_in  (side_reg[DIV_LAT-1]),
        .fold_out (fold_res)
    );

    rbsi_point u_point (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .fold_in    (fold_res),
        .word_valid (out_valid),
        .word       (out_word)
    );

endmodule

`default_nettype wire

[rtl/rbsi_div.sv]
`default_nettype none

module rbsi_div
    import rbsi_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [NW-1:0] num,
    input  wire coord_t               den,
    output coord_t                    quo,
    output logic                      sat
);

    logic [NMW-1:0] nmag_a_reg;
    logic [CB-1:0]  dmag_a_reg;
    logic           neg_a_reg;

    logic [CB-1:0]  rem_reg  [0:CB];
    logic [CB-1:0]  nq_reg   [0:CB];
    logic [CB-1:0]  dmag_reg [0:CB];
    logic           neg_reg  [0:CB];
    logic           big_reg  [0:CB];

    logic [CB-1:0]  rem_next [0:CB-1];
    logic [CB-1:0]  nq_next  [0:CB-1];

    logic [CB-1:0]  rem_init;
    logic           big_init;

    coord_t         quo_next;
    logic           sat_next;
    coord_t         quo_reg;
    logic           sat_reg;

    // high part of the numerator seeds the remainder; at or above the
    // divisor the quotient cannot fit and saturates
    assign rem_init = {{(CB-FB-1){1'b0}}, nmag_a_reg[NMW-1:CB]};
    assign big_init = rem_init >= dmag_a_reg;

    always_comb
    begin
        logic [CB:0] shifted;
        logic        ge;
        for (int k = 0; k < CB; k++)
        begin
            shifted     = {rem_reg[k], nq_reg[k][CB-1]};
            ge          = shifted >= {1'b0, dmag_reg[k]};
            rem_next[k] = ge ? CB'(shifted - {1'b0, dmag_reg[k]}) : CB'(shifted);
            nq_next[k]  = {nq_reg[k][CB-2:0], ge};
        end
    end

    always_comb
    begin
        logic [CB-1:0] q;
        q = nq_reg[CB];
        if (neg_reg[CB])
        begin
            sat_next = big_reg[CB] || (q[CB-1] && (|q[CB-2:0]));
            quo_next = sat_next ? VMIN : coord_t'(-q);
        end
        else
        begin
            sat_next = big_reg[CB] || q[CB-1];
            quo_next = sat_next ? VMAX : coord_t'(q);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag_a_reg  <= num[NW-1] ? NMW'(-num) : NMW'(num);
            dmag_a_reg  <= den[CB-1] ? CB'(-den) : CB'(den);
            neg_a_reg   <= num[NW-1] ^ den[CB-1];

            rem_reg[0]  <= rem_init;
            nq_reg[0]   <= nmag_a_reg[CB-1:0];
            dmag_reg[0] <= dmag_a_reg;
            neg_reg[0]  <= neg_a_reg;
            big_reg[0]  <= big_init;

            for (int k = 0; k < CB; k++)
            begin
                rem_reg[k+1]  <= rem_next[k];
                nq_reg[k+1]   <= nq_next[k];
                dmag_reg[k+1] <= dmag_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                big_reg[k+1]  <= big_reg[k];
            end

            quo_reg <= quo_next;
            sat_reg <= sat_next;
        end
    end

    assign quo = quo_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

[rtl/rbsi_fold.sv]
`default_nettype none

module rbsi_fold
    import rbsi_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic [2:0][CB-1:0] t1,
    input  wire logic [2:0][CB-1:0] t2,
    input  wire logic [2:0]          tsat,
    input  wire ray_side_t           side_in,
    output fold_t                    fold_out
);

    typedef struct packed {
        logic [2:0][CB-1:0] lo;
        logic [2:0][CB-1:0] hi;
        logic [2:0]          ts;
    } slab_t;

    slab_t     slab_reg [0:2];
    ray_side_t side0_reg;
    fold_t     fold_reg [0:2];
    slab_t     slab_next;
    fold_t     fold_init;

    function automatic fold_t fold_step(fold_t s, coord_t lo, coord_t hi, logic ts,
                                        logic dz, logic so, logic [1:0] ax);
        fold_t r;
        r = s;
        if (!s.miss)
        begin
            if (!dz)
            begin
                r.sat = s.sat | ts;
                if (lo > s.tmin)
                begin
                    r.tmin = lo;
                    r.axis = ax;
                end
                if (hi < s.tmax)
                    r.tmax = hi;
                if ((r.tmin > r.tmax) || r.tmax[CB-1])
                    r.miss = 1'b1;
            end
            else if (so)
            begin
                r.miss = 1'b1;
            end
        end
        return r;
    endfunction

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if ($signed(t1[i]) > $signed(t2[i]))
            begin
                slab_next.lo[i] = t2[i];
                slab_next.hi[i] = t1[i];
            end
            else
            begin
                slab_next.lo[i] = t1[i];
                slab_next.hi[i] = t2[i];
            end
        end
        slab_next.ts = tsat;
    end

    always_comb
    begin
        fold_init      = '0;
        fold_init.side = side0_reg;
        fold_init.tmin = VMIN;
        fold_init.tmax = VMAX;
        fold_init.axis = AXIS_X;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side0_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                slab_reg[k] <= '0;
                fold_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            side0_reg   <= side_in;
            slab_reg[0] <= slab_next;
            slab_reg[1] <= slab_reg[0];
            slab_reg[2] <= slab_reg[1];
            fold_reg[0] <= fold_step(fold_init, coord_t'(slab_reg[0].lo[0]),
                                     coord_t'(slab_reg[0].hi[0]), slab_reg[0].ts[0],
                                     side0_reg.dz[0], side0_reg.slab_out[0], AXIS_X);
            fold_reg[1] <= fold_step(fold_reg[0], coord_t'(slab_reg[1].lo[1]),
                                     coord_t'(slab_reg[1].hi[1]), slab_reg[1].ts[1],
                                     fold_reg[0].side.dz[1],
                                     fold_reg[0].side.slab_out[1], AXIS_Y);
            fold_reg[2] <= fold_step(fold_reg[1], coord_t'(slab_reg[2].lo[2]),
                                     coord_t'(slab_reg[2].hi[2]), slab_reg[2].ts[2],
                                     fold_reg[1].side.dz[2],
                                     fold_reg[1].side.slab_out[2], AXIS_Z);
        end
    end

    assign fold_out = fold_reg[2];

endmodule

`default_nettype wire

[rtl/rbsi_point.sv]
`default_nettype none

module rbsi_point
    import rbsi_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  en,
    input  wire fold_t fold_in,
    output logic       word_valid,
    output out_word_t  word
);

    logic                  m_valid_reg;
    logic                  m_hit_reg;
    logic [1:0]            m_axis_reg;
    logic                  m_neg_reg;
    logic                  m_sat_reg;
    logic [2:0][CB-1:0]    m_o_reg;
    logic [2:0][2*CB-1:0]  m_prod_reg;

    logic                  hit_next;
    logic                  neg_next;
    logic [2:0][2*CB-1:0]  prod_next;

    out_word_t             word_reg;
    out_word_t             word_next;
    logic                  valid_reg;

    always_comb
    begin
        hit_next = !fold_in.miss && (fold_in.tmin > 0);
        for (int i = 0; i < 3; i++)
            prod_next[i] = $signed(fold_in.side.d[i]) * fold_in.tmin;
        case (fold_in.axis)
            AXIS_X:  neg_next = $signed(fold_in.side.d[0]) > 0;
            AXIS_Y:  neg_next = $signed(fold_in.side.d[1]) > 0;
            AXIS_Z:  neg_next = $signed(fold_in.side.d[2]) > 0;
            default: neg_next = 1'b0;
        endcase
    end

    // floor of d*tmin in Q format is an arithmetic shift
    always_comb
    begin
        logic signed [2*CB:0] pt;
        coord_t               pc [3];
        logic                 psat;
        psat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            pt = $signed(m_o_reg[i]) + ($signed(m_prod_reg[i]) >>> FB);
            if (pt > VMAX)
            begin
                pc[i] = VMAX;
                psat  = 1'b1;
            end
            else if (pt < VMIN)
            begin
                pc[i] = VMIN;
                psat  = 1'b1;
            end
            else
            begin
                pc[i] = coord_t'(pt);
            end
        end
        word_next           = '0;
        word_next.saturated = m_sat_reg;
        if (m_hit_reg)
        begin
            word_next.hit             = 1'b1;
            word_next.hit_x           = pc[0];
            word_next.hit_y           = pc[1];
            word_next.hit_z           = pc[2];
            word_next.normal_axis     = m_axis_reg;
            word_next.normal_negative = m_neg_reg;
            word_next.saturated       = m_sat_reg | psat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= fold_in.side.valid;
            valid_reg   <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_hit_reg  <= hit_next;
            m_axis_reg <= fold_in.axis;
            m_neg_reg  <= neg_next;
            m_sat_reg  <= fold_in.sat;
            m_o_reg    <= fold_in.side.o;
            m_prod_reg <= prod_next;
            word_reg   <= word_next;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

`default_nettype wire

[rtl/rbsi_checker.sv]
`default_nettype none

module rbsi_checker
    import rbsi_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_stall,
    input  wire logic      out_valid,
    input  wire logic      out_stall,
    input  wire out_word_t out_word
);

    // a waiting word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("output word changed while stalled");

    // nothing moves in while the result is held
    a_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("input accepted while output stalled");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.hit |-> out_word.hit_x == 0 && out_word.hit_y == 0 &&
            out_word.hit_z == 0 && out_word.normal_axis == AXIS_X &&
            !out_word.normal_negative)
        else $error("miss word carries hit data");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_word.normal_axis == AXIS_X || out_word.normal_axis == AXIS_Y ||
            out_word.normal_axis == AXIS_Z)
        else $error("bad normal axis");

endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);

`default_nettype wire
